@@ sv/voxel_store_column_height_tracker_unit_defines.svh @@
// Assertion macros for the RTL of the voxel store height tracker.
`ifndef VOXEL_STORE_COLUMN_HEIGHT_TRACKER_UNIT_DEFINES_SVH
`define VOXEL_STORE_COLUMN_HEIGHT_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VSCH_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define VSCH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/vsch_pkg.sv @@
package vsch_pkg;

  // Fixed widths of the channel fields.
  localparam int POS_W    = 4;
  localparam int KIND_W   = 8;
  localparam int HEIGHT_W = 4;
  localparam int FACE_W   = 6;

  // Default geometry of the store.
  localparam int EDGE_DEF      = 16;
  localparam int KIND_BITS_DEF = 8;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic clear;     // clearing pass, one cell per cycle
    logic load;      // input transfer, latch the item
    logic decide;    // column top read back, write the cell
    logic scan;      // one step of the downward scan
    logic out_load;  // move the result into the output register
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic clear_last;  // last cell of the clearing pass
    logic need_scan;   // top cell above the floor turned to air, a scan must follow
    logic scan_done;   // scan found a solid cell or reached the floor
  } sts_t;

endpackage

@@ sv/vsch_if.sv @@
// Input channel: one cell write per transfer.
interface vsch_item_if;
  import vsch_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [POS_W-1:0]  pos_z;
  logic [KIND_W-1:0] cell_kind;

  modport source (output valid, pos_x, pos_y, pos_z, cell_kind, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, cell_kind, output ready);
endinterface

// Output channel: column top and sticky flags per transfer.
interface vsch_result_if;
  import vsch_pkg::*;

  logic                valid;
  logic                ready;
  logic                top_valid;
  logic [HEIGHT_W-1:0] top_height;
  logic                mesh_dirty;
  logic [FACE_W-1:0]   face_mask;

  modport source (output valid, top_valid, top_height, mesh_dirty, face_mask,
                  input ready);
  modport sink   (input valid, top_valid, top_height, mesh_dirty, face_mask,
                  output ready);
endinterface

@@ sv/voxel_store_column_height_tracker_unit.sv @@
// An accepted item passes the lookup state, then, when the top cell of a column above the
// floor is cleared, a downward scan of the column, and then the result state, which moves
// the result into the output register once that register is free. A new item is taken only
// when idle; the scan reads the cell store through its single read port, one cell per cycle.
// Reset: asynchronous, active low; afterwards a clearing pass over all EDGE^3 cells
// (4096 by default) empties both stores before the first item is taken.
module voxel_store_column_height_tracker_unit #(
  parameter int EDGE      = vsch_pkg::EDGE_DEF,
  parameter int KIND_BITS = vsch_pkg::KIND_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  vsch_item_if.sink     item_i,
  vsch_result_if.source result_o
);
  import vsch_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  vsch_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Stores, flags and result register.
  vsch_datapath #(
    .EDGE      (EDGE),
    .KIND_BITS (KIND_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .pos_x_i      (item_i.pos_x),
    .pos_y_i      (item_i.pos_y),
    .pos_z_i      (item_i.pos_z),
    .cell_kind_i  (item_i.cell_kind),
    .top_valid_o  (result_o.top_valid),
    .top_height_o (result_o.top_height),
    .mesh_dirty_o (result_o.mesh_dirty),
    .face_mask_o  (result_o.face_mask)
  );
endmodule

@@ sv/vsch_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
module vsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
endmodule

@@ sv/vsch_datapath.sv @@
// Cell store, column top store, sticky flags and the result register.
module vsch_datapath #(
  parameter int EDGE      = vsch_pkg::EDGE_DEF,
  parameter int KIND_BITS = vsch_pkg::KIND_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vsch_pkg::cmd_t                cmd_i,
  output vsch_pkg::sts_t                sts_o,
  input  logic [vsch_pkg::POS_W-1:0]    pos_x_i,
  input  logic [vsch_pkg::POS_W-1:0]    pos_y_i,
  input  logic [vsch_pkg::POS_W-1:0]    pos_z_i,
  input  logic [vsch_pkg::KIND_W-1:0]   cell_kind_i,
  output logic                          top_valid_o,
  output logic [vsch_pkg::HEIGHT_W-1:0] top_height_o,
  output logic                          mesh_dirty_o,
  output logic [vsch_pkg::FACE_W-1:0]   face_mask_o
);
  import vsch_pkg::*;

  localparam int CELL_DEPTH = EDGE * EDGE * EDGE;
  localparam int CELL_AW    = $clog2(CELL_DEPTH);
  localparam int COL_DEPTH  = EDGE * EDGE;
  localparam int COL_AW     = $clog2(COL_DEPTH);
  localparam int TW         = $clog2(EDGE + 1);
  localparam logic [TW-1:0] NO_TOP = TW'(EDGE);
  localparam logic [7:0]    EDGE_C = 8'(EDGE);
  localparam logic [7:0]    LAST_C = 8'(EDGE - 1);

  // Linear cell address, y outermost, then z, then x.
  function automatic logic [CELL_AW-1:0] cell_addr(input logic [7:0] x,
                                                   input logic [7:0] y,
                                                   input logic [7:0] z);
    cell_addr = CELL_AW'((32'(y) * EDGE + 32'(z)) * EDGE + 32'(x));
  endfunction

  function automatic logic [COL_AW-1:0] col_addr(input logic [7:0] x,
                                                 input logic [7:0] z);
    col_addr = COL_AW'(32'(z) * EDGE + 32'(x));
  endfunction

  // Latched item.
  logic [POS_W-1:0]     x_q, y_q, z_q;
  logic [KIND_BITS-1:0] kind_q;
  logic                 in_range_q;

  // Sticky state and sequencing registers.
  logic               store_empty_q, store_empty_d;
  logic               dirty_q, dirty_d;
  logic [FACE_W-1:0]  face_q, face_d;
  logic [CELL_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [POS_W-1:0]   scan_y_q, scan_y_d;
  logic [TW-1:0]      res_q, res_d;

  // Output register payload.
  logic                top_valid_q;
  logic [HEIGHT_W-1:0] top_height_q;
  logic                out_dirty_q;
  logic [FACE_W-1:0]   out_face_q;

  // Memory ports.
  logic                 cell_we;
  logic [CELL_AW-1:0]   cell_waddr, cell_raddr;
  logic [KIND_BITS-1:0] cell_wdata, cell_rdata;
  logic                 col_we;
  logic [COL_AW-1:0]    col_waddr, col_raddr;
  logic [TW-1:0]        col_wdata, col_rdata;

  logic [7:0]    x8, y8, z8, top8;
  logic          kind_zero, do_write, hit_top, need_scan, raise;
  logic          scan_hit, scan_done, in_range_in;
  logic [TW-1:0] new_top, scan_top;

  assign x8   = {4'b0, x_q};
  assign y8   = {4'b0, y_q};
  assign z8   = {4'b0, z_q};
  assign top8 = 8'(col_rdata);

  assign in_range_in = ({4'b0, pos_x_i} < EDGE_C) && ({4'b0, pos_y_i} < EDGE_C) &&
                       ({4'b0, pos_z_i} < EDGE_C);

  // Decision on the column top read back for the latched item.
  assign kind_zero = (kind_q == '0);
  assign do_write  = in_range_q && !(store_empty_q && kind_zero);
  assign hit_top   = kind_zero && (top8 == y8);
  assign need_scan = do_write && hit_top && (y_q != '0);
  assign raise     = !kind_zero && ((col_rdata == NO_TOP) || (y8 >= top8));

  always_comb begin
    if (hit_top) begin
      new_top = NO_TOP;
    end else if (raise) begin
      new_top = TW'(y8);
    end else begin
      new_top = col_rdata;
    end
  end

  // Downward scan: the cell read last cycle belongs to scan_y_q.
  assign scan_hit  = (cell_rdata != '0);
  assign scan_done = scan_hit || (scan_y_q == '0);
  assign scan_top  = scan_hit ? TW'({4'b0, scan_y_q}) : NO_TOP;

  assign sts_o.clear_last = (clr_cnt_q == CELL_AW'(CELL_DEPTH - 1));
  assign sts_o.need_scan  = need_scan;
  assign sts_o.scan_done  = scan_done;

  // Cell store ports.
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = cell_addr(x8, y8, z8);
    cell_wdata = kind_q;
    if (cmd_i.clear) begin
      cell_we    = 1'b1;
      cell_waddr = clr_cnt_q;
      cell_wdata = '0;
    end else if (cmd_i.decide) begin
      cell_we    = do_write;
    end
    if (cmd_i.decide) begin
      cell_raddr = cell_addr(x8, y8 - 8'd1, z8);
    end else begin
      cell_raddr = cell_addr(x8, {4'b0, scan_y_q} - 8'd1, z8);
    end
  end

  // Column top store ports.
  always_comb begin
    col_we    = 1'b0;
    col_waddr = col_addr(x8, z8);
    col_wdata = new_top;
    if (cmd_i.clear) begin
      col_we    = (32'(clr_cnt_q) < COL_DEPTH);
      col_waddr = clr_cnt_q[COL_AW-1:0];
      col_wdata = NO_TOP;
    end else if (cmd_i.decide) begin
      col_we    = do_write && !need_scan;
    end else if (cmd_i.scan) begin
      col_we    = scan_done;
      col_wdata = scan_top;
    end
    if (cmd_i.load) begin
      col_raddr = col_addr({4'b0, pos_x_i}, {4'b0, pos_z_i});
    end else begin
      col_raddr = col_addr(x8, z8);
    end
  end

  vsch_ram #(
    .WIDTH (KIND_BITS),
    .DEPTH (CELL_DEPTH)
  ) u_cell_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cell_we),
    .wr_addr_i (cell_waddr),
    .wr_data_i (cell_wdata),
    .rd_addr_i (cell_raddr),
    .rd_data_o (cell_rdata)
  );

  vsch_ram #(
    .WIDTH (TW),
    .DEPTH (COL_DEPTH)
  ) u_col_ram (
    .clk_i     (clk_i),
    .wr_en_i   (col_we),
    .wr_addr_i (col_waddr),
    .wr_data_i (col_wdata),
    .rd_addr_i (col_raddr),
    .rd_data_o (col_rdata)
  );

  // Next values of the sticky flags, the clear counter, the scan row and the result.
  always_comb begin
    store_empty_d = store_empty_q;
    dirty_d       = dirty_q;
    face_d        = face_q;
    clr_cnt_d     = clr_cnt_q;
    scan_y_d      = scan_y_q;
    res_d         = res_q;
    if (cmd_i.clear) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
    end
    if (cmd_i.decide) begin
      scan_y_d = y_q - 1'b1;
      if (do_write) begin
        store_empty_d = 1'b0;
        dirty_d       = 1'b1;
        face_d        = face_q | {z8 == LAST_C, z8 == 8'd0, y8 == LAST_C, y8 == 8'd0,
                                  x8 == LAST_C, x8 == 8'd0};
        res_d         = new_top;
      end else if (in_range_q) begin
        res_d = col_rdata;
      end else begin
        res_d = NO_TOP;
      end
    end
    if (cmd_i.scan) begin
      if (scan_done) begin
        res_d = scan_top;
      end else begin
        scan_y_d = scan_y_q - 1'b1;
      end
    end
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_empty_q <= 1'b1;
      dirty_q       <= 1'b0;
      face_q        <= '0;
      clr_cnt_q     <= '0;
    end else begin
      store_empty_q <= store_empty_d;
      dirty_q       <= dirty_d;
      face_q        <= face_d;
      clr_cnt_q     <= clr_cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    scan_y_q <= scan_y_d;
    res_q    <= res_d;
    if (cmd_i.load) begin
      x_q        <= pos_x_i;
      y_q        <= pos_y_i;
      z_q        <= pos_z_i;
      kind_q     <= KIND_BITS'(cell_kind_i);
      in_range_q <= in_range_in;
    end
    if (cmd_i.out_load) begin
      top_valid_q  <= (res_q != NO_TOP);
      top_height_q <= (res_q != NO_TOP) ? HEIGHT_W'(res_q) : '0;
      out_dirty_q  <= dirty_q;
      out_face_q   <= face_q;
    end
  end

  assign top_valid_o  = top_valid_q;
  assign top_height_o = top_height_q;
  assign mesh_dirty_o = out_dirty_q;
  assign face_mask_o  = out_face_q;
endmodule

@@ sv/vsch_controller.sv @@
`include "voxel_store_column_height_tracker_unit_defines.svh"

// Sequencer: clearing pass, item lookup, downward scan and result hand-off.
module vsch_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  vsch_pkg::sts_t sts_i,
  output vsch_pkg::cmd_t cmd_o
);
  import vsch_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Commands follow the state; the item is taken only when idle.
  always_comb begin
    cmd_o          = '0;
    state_d        = state_q;
    cmd_o.clear    = (state_q == ST_CLEAR);
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.decide   = (state_q == ST_LOOKUP);
    cmd_o.scan     = (state_q == ST_SCAN);
    cmd_o.out_load = (state_q == ST_RESP) && slot_free;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = sts_i.need_scan ? ST_SCAN : ST_RESP;
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // The output slot fills on a result and empties on a transfer.
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  `VSCH_ASSERT_NEXT(a_accept_to_lookup, clk_i, rst_ni,
                    in_valid_i && in_ready_o, state_q == ST_LOOKUP, "transfer did not start a lookup")
  `VSCH_ASSERT_NEXT(a_scan_holds, clk_i, rst_ni,
                    state_q == ST_SCAN && !sts_i.scan_done, state_q == ST_SCAN, "scan left early")
  `VSCH_ASSERT_NEXT(a_result_posted, clk_i, rst_ni,
                    cmd_o.out_load, out_valid_q && state_q == ST_IDLE, "result not posted")
  `VSCH_ASSERT_SAME(a_cmd_exclusive, clk_i, rst_ni, 1'b1,
                    $onehot0({cmd_o.clear, cmd_o.load, cmd_o.decide, cmd_o.scan, cmd_o.out_load}),
                    "overlapping datapath commands")
endmodule

@@ bench/tb_voxel_store_column_height_tracker_unit.sv @@
module tb_voxel_store_column_height_tracker_unit;
  import vsch_pkg::*;

  localparam int EDGE         = EDGE_DEF;
  localparam int KIND_BITS    = KIND_BITS_DEF;
  localparam int RANDOM_ITEMS = 1500;
  localparam int TAIL_ITEMS   = 150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AFTER   = 200;
  localparam int N_DIRECTED   = 19;
  localparam int N_HOT        = 4;

  localparam logic [KIND_W-1:0] KIND_AIR  = '0;
  localparam logic [KIND_W-1:0] KIND_MASK = KIND_W'((1 << KIND_BITS) - 1);

  // Bit positions of the boundary faces in the face mask.
  localparam int FACE_X_LO = 0;
  localparam int FACE_X_HI = 1;
  localparam int FACE_Y_LO = 2;
  localparam int FACE_Y_HI = 3;
  localparam int FACE_Z_LO = 4;
  localparam int FACE_Z_HI = 5;

  localparam logic [FACE_W-1:0] FACES_NONE   = '0;
  localparam logic [FACE_W-1:0] FACES_ORIGIN =
      FACE_W'((1 << FACE_X_LO) | (1 << FACE_Y_LO) | (1 << FACE_Z_LO));
  localparam logic [FACE_W-1:0] FACES_ALL    = '1;

  typedef struct packed {
    logic                top_valid;
    logic [HEIGHT_W-1:0] top_height;
    logic                mesh_dirty;
    logic [FACE_W-1:0]   face_mask;
  } column_report_t;

  typedef struct packed {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  z;
    logic [KIND_W-1:0] kind;
    logic              typed_in;
    column_report_t    report;
  } write_row_t;

  localparam column_report_t NO_REPORT = '0;

  logic clk_i = 1'b0;
  logic rst_ni;

  vsch_item_if   item_bus ();
  vsch_result_if result_bus ();

  voxel_store_column_height_tracker_unit #(
    .EDGE      (EDGE),
    .KIND_BITS (KIND_BITS)
  ) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (result_bus)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the store, indexed [x][y][z], and of the column tops.
  logic [KIND_W-1:0] shadow_cells [EDGE][EDGE][EDGE];
  int                shadow_top   [EDGE][EDGE];
  logic              shadow_empty;
  logic              shadow_dirty;
  logic [FACE_W-1:0] shadow_faces;

  column_report_t awaited_reports [$];
  logic           failed = 1'b0;
  logic           tail_phase = 1'b0;
  int             reports_taken = 0;

  // Directed writes: empty-store air, extremes of coordinates and kinds,
  // tops raised, kept and lowered, scans down to a cell and to the floor.
  write_row_t directed_rows [N_DIRECTED] = '{
    '{4'd5,  4'd5,  4'd5,  KIND_AIR, 1'b1, '{1'b0, 4'd0,  1'b0, FACES_NONE}},
    '{4'd0,  4'd0,  4'd0,  KIND_AIR, 1'b1, '{1'b0, 4'd0,  1'b0, FACES_NONE}},
    '{4'd0,  4'd0,  4'd0,  8'hFF,    1'b1, '{1'b1, 4'd0,  1'b1, FACES_ORIGIN}},
    '{4'd15, 4'd15, 4'd15, 8'h01,    1'b1, '{1'b1, 4'd15, 1'b1, FACES_ALL}},
    '{4'd3,  4'd10, 4'd4,  8'h07,    1'b0, NO_REPORT},
    '{4'd3,  4'd2,  4'd4,  8'h09,    1'b0, NO_REPORT},
    '{4'd3,  4'd10, 4'd4,  8'h0C,    1'b0, NO_REPORT},
    '{4'd3,  4'd5,  4'd4,  KIND_AIR, 1'b0, NO_REPORT},
    '{4'd3,  4'd10, 4'd4,  KIND_AIR, 1'b0, NO_REPORT},
    '{4'd3,  4'd2,  4'd4,  KIND_AIR, 1'b0, NO_REPORT},
    '{4'd0,  4'd0,  4'd0,  KIND_AIR, 1'b0, NO_REPORT},
    '{4'd15, 4'd0,  4'd15, 8'h80,    1'b0, NO_REPORT},
    '{4'd15, 4'd15, 4'd15, KIND_AIR, 1'b0, NO_REPORT},
    '{4'd15, 4'd0,  4'd15, KIND_AIR, 1'b0, NO_REPORT},
    '{4'd7,  4'd7,  4'd7,  KIND_AIR, 1'b0, NO_REPORT},
    '{4'd8,  4'd15, 4'd8,  8'hAA,    1'b0, NO_REPORT},
    '{4'd8,  4'd15, 4'd8,  8'h55,    1'b0, NO_REPORT},
    '{4'd8,  4'd3,  4'd8,  8'h10,    1'b0, NO_REPORT},
    '{4'd8,  4'd15, 4'd8,  KIND_AIR, 1'b0, NO_REPORT}
  };

  // Applies one cell write to the shadow store and returns the column report.
  function automatic column_report_t apply_cell_write(
      input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
      input logic [POS_W-1:0] z, input logic [KIND_W-1:0] kind_in);
    logic [KIND_W-1:0] kind;
    int                top;
    int                yy;
    column_report_t    report;
    kind = kind_in & KIND_MASK;
    top  = EDGE;
    if (x < EDGE && y < EDGE && z < EDGE) begin
      if (!(shadow_empty && kind == KIND_AIR)) begin
        shadow_empty = 1'b0;
        shadow_cells[x][y][z] = kind;
        shadow_dirty = 1'b1;
        if (x == 0)        shadow_faces[FACE_X_LO] = 1'b1;
        if (x == EDGE - 1) shadow_faces[FACE_X_HI] = 1'b1;
        if (y == 0)        shadow_faces[FACE_Y_LO] = 1'b1;
        if (y == EDGE - 1) shadow_faces[FACE_Y_HI] = 1'b1;
        if (z == 0)        shadow_faces[FACE_Z_LO] = 1'b1;
        if (z == EDGE - 1) shadow_faces[FACE_Z_HI] = 1'b1;
        // Clearing the top cell: look down the column for the next solid one.
        if (kind == KIND_AIR && shadow_top[x][z] == int'(y)) begin
          yy = int'(y) - 1;
          while (yy >= 0 && shadow_cells[x][yy][z] == KIND_AIR) yy--;
          shadow_top[x][z] = (yy >= 0) ? yy : EDGE;
        end
        if (kind != KIND_AIR &&
            (shadow_top[x][z] == EDGE || int'(y) >= shadow_top[x][z])) begin
          shadow_top[x][z] = int'(y);
        end
      end
      top = shadow_top[x][z];
    end
    report.top_valid  = (top != EDGE);
    report.top_height = (top != EDGE) ? HEIGHT_W'(top) : '0;
    report.mesh_dirty = shadow_dirty;
    report.face_mask  = shadow_faces;
    return report;
  endfunction

  // Offers one write, after an optional idle burst, and records its report
  // once the transfer has taken place.
  task automatic offer_cell_write(
      input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
      input logic [POS_W-1:0] z, input logic [KIND_W-1:0] kind,
      input logic typed_in, input column_report_t typed_report);
    int             gap;
    column_report_t report;
    gap = 0;
    if (!tail_phase && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_bus.valid     <= 1'b1;
    item_bus.pos_x     <= x;
    item_bus.pos_y     <= y;
    item_bus.pos_z     <= z;
    item_bus.cell_kind <= kind;
    do @(posedge clk_i); while (item_bus.ready !== 1'b1);
    report = apply_cell_write(x, y, z, kind);
    awaited_reports = {awaited_reports, typed_in ? typed_report : report};
  endtask

  // Stimulus: reset, directed table, then random writes biased to a few columns.
  initial begin
    logic [POS_W-1:0]  hot_x [N_HOT];
    logic [POS_W-1:0]  hot_z [N_HOT];
    logic [POS_W-1:0]  x, y, z;
    logic [KIND_W-1:0] kind;
    int                pick;
    rst_ni             = 1'b0;
    item_bus.valid     = 1'b0;
    item_bus.pos_x     = '0;
    item_bus.pos_y     = '0;
    item_bus.pos_z     = '0;
    item_bus.cell_kind = '0;
    shadow_empty = 1'b1;
    shadow_dirty = 1'b0;
    shadow_faces = '0;
    for (int i = 0; i < EDGE; i++) begin
      for (int k = 0; k < EDGE; k++) begin
        shadow_top[i][k] = EDGE;
        for (int j = 0; j < EDGE; j++) shadow_cells[i][j][k] = KIND_AIR;
      end
    end
    for (int h = 0; h < N_HOT; h++) begin
      hot_x[h] = POS_W'($urandom_range(0, EDGE - 1));
      hot_z[h] = POS_W'($urandom_range(0, EDGE - 1));
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_cell_write(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                       directed_rows[i].kind, directed_rows[i].typed_in,
                       directed_rows[i].report);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      tail_phase = (n >= RANDOM_ITEMS - TAIL_ITEMS);
      x    = POS_W'($urandom_range(0, EDGE - 1));
      y    = POS_W'($urandom_range(0, EDGE - 1));
      z    = POS_W'($urandom_range(0, EDGE - 1));
      kind = KIND_W'($urandom_range(0, (1 << KIND_W) - 1));
      // Most writes build and tear down a few columns so that scans happen.
      if ($urandom_range(0, 99) < 75) begin
        pick = $urandom_range(0, N_HOT - 1);
        x    = hot_x[pick];
        z    = hot_z[pick];
        if ($urandom_range(0, 99) < 45) begin
          kind = KIND_AIR;
          if (shadow_top[x][z] != EDGE && $urandom_range(0, 1) == 1)
            y = POS_W'(shadow_top[x][z]);
        end else if (kind == KIND_AIR) begin
          kind = KIND_W'($urandom_range(1, (1 << KIND_W) - 1));
        end
      end
      offer_cell_write(x, y, z, kind, 1'b0, NO_REPORT);
    end
    item_bus.valid <= 1'b0;

    while (awaited_reports.size() != 0) @(posedge clk_i);
    repeat (EDGE + 8) @(posedge clk_i);
    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off, and a check per transfer.
  initial begin
    column_report_t want;
    int             stall_left;
    logic           long_done;
    stall_left = 0;
    long_done  = 1'b0;
    result_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
        reports_taken++;
        if (awaited_reports.size() == 0) begin
          $error("unexpected result transfer with nothing awaited");
          failed = 1'b1;
        end else begin
          want = awaited_reports.pop_front();
          if (result_bus.top_valid !== want.top_valid) begin
            $error("top_valid: expected %0d, got %0d", want.top_valid,
                   result_bus.top_valid);
            failed = 1'b1;
          end
          if (result_bus.top_height !== want.top_height) begin
            $error("top_height: expected %0d, got %0d", want.top_height,
                   result_bus.top_height);
            failed = 1'b1;
          end
          if (result_bus.mesh_dirty !== want.mesh_dirty) begin
            $error("mesh_dirty: expected %0d, got %0d", want.mesh_dirty,
                   result_bus.mesh_dirty);
            failed = 1'b1;
          end
          if (result_bus.face_mask !== want.face_mask) begin
            $error("face_mask: expected 0x%0h, got 0x%0h", want.face_mask,
                   result_bus.face_mask);
            failed = 1'b1;
          end
        end
      end
      // Hold off for a long stretch once, so that the block backs up.
      if (!long_done && reports_taken == HOLD_AFTER) begin
        long_done  = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the total number of cycles.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
